// ===== hdl/srsi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsi_pkg: shared types and constants for the stochastic RSI stream
// Window sizes, field widths, cell lane controls and period clamping.
// ----------------------------------------------------------------------------
package srsi_pkg;

   localparam int MaxWindow  = 64;
   localparam int PriceDepth = MaxWindow + 1;
   localparam int PriceBits  = 32;
   localparam int RegW       = 7;
   localparam int RsiW       = 15;
   localparam int FracW      = 17;
   localparam int GainW      = PriceBits + $clog2(MaxWindow);
   localparam int SumW       = FracW + $clog2(MaxWindow);
   localparam int CntW       = $clog2(PriceDepth + 1);
   localparam int NumW       = GainW + RsiW;
   localparam int DenW       = GainW + 1;
   localparam int QuotW      = FracW;
   localparam int AddrW      = 4;
   localparam int DataW      = 32;

   localparam int RsiFull = 25600;
   localparam int UnitQ16 = 65536;

   localparam logic [1:0] OpHold   = 2'd0;
   localparam logic [1:0] OpShift  = 2'd1;
   localparam logic [1:0] OpRotate = 2'd2;

   localparam logic [1:0] RegRsiPeriod   = 2'd0;
   localparam logic [1:0] RegStochPeriod = 2'd1;
   localparam logic [1:0] RegSmoothK     = 2'd2;
   localparam logic [1:0] RegSmoothD     = 2'd3;

   typedef struct packed {
      logic [1:0] price_op;
      logic [1:0] rsi_op;
      logic [1:0] raw_op;
      logic [1:0] k_op;
   } lane_ctl_type;

   typedef struct packed {
      logic [PriceBits-1:0] price;
      logic [RsiW-1:0]      rsi;
      logic [FracW-1:0]     raw;
      logic [FracW-1:0]     k;
   } cell_data_type;

   // A period of zero acts as one, and anything above the window acts as the window.
   function automatic logic [RegW-1:0] eff_len(input logic [RegW-1:0] v);
      logic [RegW-1:0] r;
      r = v;
      if (v == '0) begin
         r = RegW'(1);
      end else if (v > RegW'(MaxWindow)) begin
         r = RegW'(MaxWindow);
      end
      return r;
   endfunction

endpackage

// ===== hdl/srsi_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsi_cell: one history cell of the window chain
// Holds one price, RSI, raw and K entry; each lane holds, shifts or rotates.
// ----------------------------------------------------------------------------
module srsi_cell import srsi_pkg::*; (
   input  logic          clock,
   input  lane_ctl_type  ctl,
   input  cell_data_type shift_src,
   input  cell_data_type rot_src,
   output cell_data_type data
);

   cell_data_type data_ff, data_in;

   always_comb begin
      data_in = data_ff;
      case (ctl.price_op)
         OpShift:  data_in.price = shift_src.price;
         OpRotate: data_in.price = rot_src.price;
         default:  data_in.price = data_ff.price;
      endcase
      case (ctl.rsi_op)
         OpShift:  data_in.rsi = shift_src.rsi;
         OpRotate: data_in.rsi = rot_src.rsi;
         default:  data_in.rsi = data_ff.rsi;
      endcase
      case (ctl.raw_op)
         OpShift:  data_in.raw = shift_src.raw;
         OpRotate: data_in.raw = rot_src.raw;
         default:  data_in.raw = data_ff.raw;
      endcase
      case (ctl.k_op)
         OpShift:  data_in.k = shift_src.k;
         OpRotate: data_in.k = rot_src.k;
         default:  data_in.k = data_ff.k;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ===== hdl/srsi_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsi_div: shared restoring divider
// One quotient bit per cycle, with optional round-half-up from the remainder.
// ----------------------------------------------------------------------------
module srsi_div import srsi_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NumW-1:0]  num,
   input  logic [DenW-1:0]  den,
   input  logic             round_en,
   output logic             done,
   output logic [QuotW-1:0] quotient
);

   localparam int StepW = $clog2(QuotW);

   logic             busy_ff, busy_in;
   logic             fin_ff, fin_in;
   logic             done_ff, done_in;
   logic [StepW-1:0] step_ff, step_in;
   logic [DenW-1:0]  rem_ff, rem_in;
   logic [QuotW-1:0] low_ff, low_in;
   logic [QuotW-1:0] q_ff, q_in;
   logic [DenW-1:0]  den_ff, den_in;
   logic             rnd_ff, rnd_in;
   logic [QuotW-1:0] quot_ff, quot_in;
   logic [DenW:0]    trial;
   logic             fits;
   logic             bump;

   always_comb begin
      trial   = {rem_ff, low_ff[QuotW-1]};
      fits    = trial >= {1'b0, den_ff};
      bump    = rnd_ff && ({rem_ff, 1'b0} >= {1'b0, den_ff});
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      rnd_in  = rnd_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = DenW'(num[NumW-1:QuotW]);
         low_in  = num[QuotW-1:0];
         q_in    = '0;
         den_in  = den;
         rnd_in  = round_en;
      end else if (busy_ff) begin
         rem_in  = fits ? DenW'(trial - {1'b0, den_ff}) : DenW'(trial);
         low_in  = {low_ff[QuotW-2:0], 1'b0};
         q_in    = {q_ff[QuotW-2:0], fits};
         step_in = StepW'(step_ff + 1'b1);
         if (step_ff == StepW'(QuotW - 1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         quot_in = QuotW'(q_ff + QuotW'(bump));
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      q_ff    <= q_in;
      den_ff  <= den_in;
      rnd_ff  <= rnd_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// ===== hdl/stochastic_rsi_stream.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stochastic_rsi_stream: streaming stochastic RSI indicator
// Price words in, one word of RSI, raw stochastic, %K and %D out per price.
// ----------------------------------------------------------------------------
// Each price word on the req channel produces exactly one result word on the
// rsp channel. Both channels use valid and stall; a word moves at a clock edge
// where valid is high and stall is low. The four period registers sit on an
// APB-style port at byte addresses 0, 4, 8 and 12; the user must see that they
// are written only while idle, which the block does not enforce. The history
// lives in a chain of 65 identical cells, each holding one price, RSI, raw and
// %K entry. A new value shifts in at the head of its lane, and a window is
// scanned by rotating that lane once around the whole chain, reading the head
// cells as the entries go by, which restores the order at the end. Each price
// passes four such scans (price changes, RSI min and max, raw sum and %K sum),
// each followed by a decision state that may start a division on the shared
// divider and wait for it; the first three results are pushed into the chain.
// One price is worked on at a time: none is accepted until the last has left
// the output state. While a finished word waits on a stalled rsp channel the
// next price is already accepted and processed; it waits at the end until the
// output register is free. Synchronous reset empties every window, restores
// the default periods and drops any pending result.
// ----------------------------------------------------------------------------
module stochastic_rsi_stream import srsi_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [PriceBits-1:0] req_price,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [RsiW-1:0]      rsp_rsi_value,
   output logic [FracW-1:0]     rsp_stoch_raw,
   output logic [FracW-1:0]     rsp_stoch_k,
   output logic [FracW-1:0]     rsp_stoch_d,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [AddrW-1:0]     paddr,
   input  logic [DataW-1:0]     pwdata,
   output logic [DataW-1:0]     prdata,
   output logic                 pready
);

   localparam logic [4:0] StIdle  = 5'd0;
   localparam logic [4:0] StPscan = 5'd1;
   localparam logic [4:0] StRdec  = 5'd2;
   localparam logic [4:0] StRdiv  = 5'd3;
   localparam logic [4:0] StRpush = 5'd4;
   localparam logic [4:0] StSscan = 5'd5;
   localparam logic [4:0] StSdec  = 5'd6;
   localparam logic [4:0] StSdiv  = 5'd7;
   localparam logic [4:0] StSpush = 5'd8;
   localparam logic [4:0] StKscan = 5'd9;
   localparam logic [4:0] StKdec  = 5'd10;
   localparam logic [4:0] StKdiv  = 5'd11;
   localparam logic [4:0] StKpush = 5'd12;
   localparam logic [4:0] StDscan = 5'd13;
   localparam logic [4:0] StDdec  = 5'd14;
   localparam logic [4:0] StDdiv  = 5'd15;
   localparam logic [4:0] StOut   = 5'd16;

   localparam logic [CntW-1:0] ScanLast = CntW'(PriceDepth - 1);

   // Configuration registers.
   logic [RegW-1:0] rsi_period_ff, stoch_period_ff, smooth_k_ff, smooth_d_ff;
   logic            cfg_write;

   // Control state.
   logic [4:0]      state_ff, state_in;
   logic [CntW-1:0] scan_ff, scan_in;
   logic [RegW-1:0] len_ff, len_in;
   logic [CntW-1:0] price_count_ff, price_count_in;
   logic [CntW-1:0] rsi_count_ff, rsi_count_in;
   logic [CntW-1:0] raw_count_ff, raw_count_in;
   logic [CntW-1:0] k_count_ff, k_count_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // Working values.
   logic [GainW-1:0] gain_ff, gain_in;
   logic [GainW-1:0] loss_ff, loss_in;
   logic [RsiW-1:0]  lo_ff, lo_in;
   logic [RsiW-1:0]  hi_ff, hi_in;
   logic [SumW-1:0]  sum_ff, sum_in;
   logic [RsiW-1:0]  rsi_res_ff, rsi_res_in;
   logic [FracW-1:0] raw_res_ff, raw_res_in;
   logic [FracW-1:0] k_res_ff, k_res_in;
   logic [FracW-1:0] d_res_ff, d_res_in;

   // Output register.
   logic [RsiW-1:0]  out_rsi_ff, out_rsi_in;
   logic [FracW-1:0] out_raw_ff, out_raw_in;
   logic [FracW-1:0] out_k_ff, out_k_in;
   logic [FracW-1:0] out_d_ff, out_d_in;

   // Divider hookup.
   logic             div_start;
   logic [NumW-1:0]  div_num;
   logic [DenW-1:0]  div_den;
   logic             div_round;
   logic             div_done;
   logic [QuotW-1:0] div_quot;

   // Cell chain.
   lane_ctl_type    lane_ctl;
   cell_data_type   head_entry;
   cell_data_type   cell_q [PriceDepth];

   logic            req_take;
   logic            rsp_take;
   logic            out_free;
   logic [CntW-1:0] price_count_next;
   logic [RegW-1:0] rsi_len;
   logic [PriceBits-1:0] cur_price, prev_price;
   logic [RsiW-1:0] tap_rsi;

   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != StIdle);
   assign cfg_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   // Configuration port.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsi_period_ff   <= RegW'(14);
         stoch_period_ff <= RegW'(14);
         smooth_k_ff     <= RegW'(3);
         smooth_d_ff     <= RegW'(3);
      end else if (cfg_write) begin
         case (paddr[3:2])
            RegRsiPeriod:   rsi_period_ff   <= pwdata[RegW-1:0];
            RegStochPeriod: stoch_period_ff <= pwdata[RegW-1:0];
            RegSmoothK:     smooth_k_ff     <= pwdata[RegW-1:0];
            RegSmoothD:     smooth_d_ff     <= pwdata[RegW-1:0];
            default:        rsi_period_ff   <= rsi_period_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         RegRsiPeriod:   prdata = DataW'(rsi_period_ff);
         RegStochPeriod: prdata = DataW'(stoch_period_ff);
         RegSmoothK:     prdata = DataW'(smooth_k_ff);
         RegSmoothD:     prdata = DataW'(smooth_d_ff);
         default:        prdata = '0;
      endcase
   end

   // The head cells are the taps every scan reads as the chain rotates.
   assign cur_price  = cell_q[0].price;
   assign prev_price = cell_q[1].price;
   assign tap_rsi    = cell_q[0].rsi;

   assign head_entry.price = req_price;
   assign head_entry.rsi   = rsi_res_ff;
   assign head_entry.raw   = raw_res_ff;
   assign head_entry.k     = k_res_ff;

   // Price count after the incoming price is counted, and the change window.
   assign price_count_next = (price_count_ff == CntW'(PriceDepth)) ?
                             price_count_ff : CntW'(price_count_ff + 1'b1);
   assign rsi_len = (eff_len(rsi_period_ff) > RegW'(price_count_next - 1'b1)) ?
                    RegW'(price_count_next - 1'b1) : eff_len(rsi_period_ff);

   always_comb begin
      state_in       = state_ff;
      scan_in        = scan_ff;
      len_in         = len_ff;
      price_count_in = price_count_ff;
      rsi_count_in   = rsi_count_ff;
      raw_count_in   = raw_count_ff;
      k_count_in     = k_count_ff;
      gain_in        = gain_ff;
      loss_in        = loss_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      sum_in         = sum_ff;
      rsi_res_in     = rsi_res_ff;
      raw_res_in     = raw_res_ff;
      k_res_in       = k_res_ff;
      d_res_in       = d_res_ff;
      out_rsi_in     = out_rsi_ff;
      out_raw_in     = out_raw_ff;
      out_k_in       = out_k_ff;
      out_d_in       = out_d_ff;
      rsp_valid_in   = rsp_take ? 1'b0 : rsp_valid_ff;
      lane_ctl       = '{OpHold, OpHold, OpHold, OpHold};
      div_start      = 1'b0;
      div_num        = '0;
      div_den        = '0;
      div_round      = 1'b0;

      case (state_ff)
         StIdle: begin
            if (req_take) begin
               lane_ctl.price_op = OpShift;
               price_count_in    = price_count_next;
               len_in            = rsi_len;
               scan_in           = '0;
               gain_in           = '0;
               loss_in           = '0;
               state_in          = StPscan;
            end
         end
         StPscan: begin
            lane_ctl.price_op = OpRotate;
            if (RegW'(scan_ff) < len_ff) begin
               if (cur_price > prev_price) begin
                  gain_in = GainW'(gain_ff + GainW'(cur_price - prev_price));
               end else begin
                  loss_in = GainW'(loss_ff + GainW'(prev_price - cur_price));
               end
            end
            scan_in = CntW'(scan_ff + 1'b1);
            if (scan_ff == ScanLast) begin
               state_in = StRdec;
            end
         end
         StRdec: begin
            if (price_count_ff < CntW'(2)) begin
               rsi_res_in = '0;
               state_in   = StRpush;
            end else if (loss_ff == '0) begin
               rsi_res_in = RsiW'(RsiFull);
               state_in   = StRpush;
            end else begin
               div_start = 1'b1;
               div_num   = NumW'(NumW'(gain_ff) * NumW'(RsiFull));
               div_den   = DenW'(gain_ff) + DenW'(loss_ff);
               div_round = 1'b1;
               state_in  = StRdiv;
            end
         end
         StRdiv: begin
            if (div_done) begin
               rsi_res_in = div_quot[RsiW-1:0];
               state_in   = StRpush;
            end
         end
         StRpush: begin
            lane_ctl.rsi_op = OpShift;
            if (rsi_count_ff != CntW'(MaxWindow)) begin
               rsi_count_in = CntW'(rsi_count_ff + 1'b1);
            end
            len_in   = eff_len(stoch_period_ff);
            scan_in  = '0;
            state_in = StSscan;
         end
         StSscan: begin
            lane_ctl.rsi_op = OpRotate;
            if (scan_ff == '0) begin
               lo_in = tap_rsi;
               hi_in = tap_rsi;
            end else if (RegW'(scan_ff) < len_ff) begin
               if (tap_rsi < lo_ff) begin
                  lo_in = tap_rsi;
               end
               if (tap_rsi > hi_ff) begin
                  hi_in = tap_rsi;
               end
            end
            scan_in = CntW'(scan_ff + 1'b1);
            if (scan_ff == ScanLast) begin
               state_in = StSdec;
            end
         end
         StSdec: begin
            if ((RegW'(rsi_count_ff) >= len_ff) && (hi_ff != lo_ff)) begin
               div_start = 1'b1;
               div_num   = NumW'({RsiW'(rsi_res_ff - lo_ff), 16'h0000});
               div_den   = DenW'(RsiW'(hi_ff - lo_ff));
               div_round = 1'b1;
               state_in  = StSdiv;
            end else begin
               raw_res_in = '0;
               state_in   = StSpush;
            end
         end
         StSdiv: begin
            if (div_done) begin
               raw_res_in = div_quot;
               state_in   = StSpush;
            end
         end
         StSpush: begin
            lane_ctl.raw_op = OpShift;
            if (raw_count_ff != CntW'(MaxWindow)) begin
               raw_count_in = CntW'(raw_count_ff + 1'b1);
            end
            len_in   = eff_len(smooth_k_ff);
            scan_in  = '0;
            sum_in   = '0;
            state_in = StKscan;
         end
         StKscan: begin
            lane_ctl.raw_op = OpRotate;
            if (RegW'(scan_ff) < len_ff) begin
               sum_in = SumW'(sum_ff + SumW'(cell_q[0].raw));
            end
            scan_in = CntW'(scan_ff + 1'b1);
            if (scan_ff == ScanLast) begin
               state_in = StKdec;
            end
         end
         StKdec: begin
            if (RegW'(raw_count_ff) >= len_ff) begin
               div_start = 1'b1;
               div_num   = NumW'(sum_ff) + NumW'(len_ff >> 1);
               div_den   = DenW'(len_ff);
               state_in  = StKdiv;
            end else begin
               k_res_in = '0;
               state_in = StKpush;
            end
         end
         StKdiv: begin
            if (div_done) begin
               k_res_in = div_quot;
               state_in = StKpush;
            end
         end
         StKpush: begin
            lane_ctl.k_op = OpShift;
            if (k_count_ff != CntW'(MaxWindow)) begin
               k_count_in = CntW'(k_count_ff + 1'b1);
            end
            len_in   = eff_len(smooth_d_ff);
            scan_in  = '0;
            sum_in   = '0;
            state_in = StDscan;
         end
         StDscan: begin
            lane_ctl.k_op = OpRotate;
            if (RegW'(scan_ff) < len_ff) begin
               sum_in = SumW'(sum_ff + SumW'(cell_q[0].k));
            end
            scan_in = CntW'(scan_ff + 1'b1);
            if (scan_ff == ScanLast) begin
               state_in = StDdec;
            end
         end
         StDdec: begin
            if (RegW'(k_count_ff) >= len_ff) begin
               div_start = 1'b1;
               div_num   = NumW'(sum_ff) + NumW'(len_ff >> 1);
               div_den   = DenW'(len_ff);
               state_in  = StDdiv;
            end else begin
               d_res_in = '0;
               state_in = StOut;
            end
         end
         StDdiv: begin
            if (div_done) begin
               d_res_in = div_quot;
               state_in = StOut;
            end
         end
         StOut: begin
            // The finished word waits here until the output register is free.
            if (out_free) begin
               out_rsi_in   = rsi_res_ff;
               out_raw_in   = raw_res_ff;
               out_k_in     = k_res_ff;
               out_d_in     = d_res_ff;
               rsp_valid_in = 1'b1;
               state_in     = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= StIdle;
         price_count_ff <= '0;
         rsi_count_ff   <= '0;
         raw_count_ff   <= '0;
         k_count_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
         scan_ff        <= '0;
         len_ff         <= '0;
      end else begin
         state_ff       <= state_in;
         price_count_ff <= price_count_in;
         rsi_count_ff   <= rsi_count_in;
         raw_count_ff   <= raw_count_in;
         k_count_ff     <= k_count_in;
         rsp_valid_ff   <= rsp_valid_in;
         scan_ff        <= scan_in;
         len_ff         <= len_in;
      end
      gain_ff    <= gain_in;
      loss_ff    <= loss_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      sum_ff     <= sum_in;
      rsi_res_ff <= rsi_res_in;
      raw_res_ff <= raw_res_in;
      k_res_ff   <= k_res_in;
      d_res_ff   <= d_res_in;
      out_rsi_ff <= out_rsi_in;
      out_raw_ff <= out_raw_in;
      out_k_ff   <= out_k_in;
      out_d_ff   <= out_d_in;
   end

   srsi_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .den      (div_den),
      .round_en (div_round),
      .done     (div_done),
      .quotient (div_quot)
   );

   for (genvar gi = 0; gi < PriceDepth; gi++) begin : g_cell
      cell_data_type shift_src, rot_src;
      if (gi == 0) begin : g_head
         assign shift_src = head_entry;
      end else begin : g_body
         assign shift_src = cell_q[gi-1];
      end
      if (gi == PriceDepth - 1) begin : g_tail
         assign rot_src = cell_q[0];
      end else begin : g_link
         assign rot_src = cell_q[gi+1];
      end
      srsi_cell u_cell (
         .clock     (clock),
         .ctl       (lane_ctl),
         .shift_src (shift_src),
         .rot_src   (rot_src),
         .data      (cell_q[gi])
      );
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_rsi_value = out_rsi_ff;
   assign rsp_stoch_raw = out_raw_ff;
   assign rsp_stoch_k   = out_k_ff;
   assign rsp_stoch_d   = out_d_ff;

   a_rsi_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (out_rsi_ff <= RsiW'(RsiFull)))
      else $error("RSI result above full scale");

   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((out_raw_ff <= FracW'(UnitQ16)) && (out_k_ff <= FracW'(UnitQ16))
                        && (out_d_ff <= FracW'(UnitQ16))))
      else $error("stochastic result above one");

   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == StPscan))
      else $error("accepted price did not start the change scan");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (price_count_ff <= CntW'(PriceDepth)) && (rsi_count_ff <= CntW'(MaxWindow)))
      else $error("window fill count out of range");

endmodule
